// File: rtl/sdlt_pkg.sv
// shared types and constants for the signal decay lifecycle table
package sdlt_pkg;

    localparam int SLOTS     = 16;
    localparam int SLOT_W    = $clog2(SLOTS);
    localparam int CNT_W     = $clog2(SLOTS + 1);
    localparam int FRAC_W    = 17;
    localparam int MAG_W     = 16;
    localparam int TICK_W    = 32;
    localparam int SUM_W     = 48;
    localparam int MEAN_W    = 40;
    localparam int DIVD_W    = SUM_W + 8;
    localparam int DIV_CNT_W = $clog2(DIVD_W + 1);

    typedef enum logic [1:0] {
        ACT_RECORD = 2'd0,
        ACT_TICK   = 2'd1,
        ACT_CLEAR  = 2'd2,
        ACT_NONE   = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        KIND_STATS  = 2'd0,
        KIND_DEATH  = 2'd1,
        KIND_ZOMBIE = 2'd2,
        KIND_RSVD   = 2'd3
    } kind_t;

    localparam logic [1:0] REG_HALFLIFE = 2'd0;
    localparam logic [1:0] REG_DEATH    = 2'd1;
    localparam logic [1:0] REG_MAXAGE   = 2'd2;

    // controller to datapath
    typedef struct packed {
        logic              load;       // capture input word
        logic              record;     // apply record to table
        logic              tick_inc;   // advance now tick
        logic              clear;      // clear table and counters
        logic              scan;       // evaluate slot at scan_idx
        logic              commit_die; // free slots marked dead
        logic [SLOT_W-1:0] scan_idx;
        logic              div_start;
        logic              out_load;
        kind_t             out_kind;
        logic [SLOT_W-1:0] out_slot;
    } sdlt_cmd_t;

    // datapath to controller
    typedef struct packed {
        action_t           action;
        logic [SLOTS-1:0]  die_mask;
        logic [SLOTS-1:0]  zomb_mask;
        logic              div_busy;
        logic              out_full;
    } sdlt_sts_t;

endpackage

// File: rtl/sdlt_div.sv
// restoring divider, one quotient bit per cycle, for the mean half-life
module sdlt_div (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        start,
    input  logic [sdlt_pkg::DIVD_W-1:0] dividend,
    input  logic [31:0]                 divisor,
    output logic                        busy,
    output logic [sdlt_pkg::MEAN_W-1:0] mean
);
    import sdlt_pkg::*;

    logic                 busy_reg, busy_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [DIVD_W-1:0]    quo_reg, quo_next;
    logic [32:0]          rem_reg, rem_next;
    logic [31:0]          dsr_reg, dsr_next;
    logic [32:0]          shifted;
    logic [32:0]          diff;

    always_comb begin
        shifted   = {rem_reg[31:0], quo_reg[DIVD_W-1]};
        diff      = shifted - {1'b0, dsr_reg};
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = DIV_CNT_W'(DIVD_W);
            quo_next  = dividend;
            rem_next  = '0;
            dsr_next  = divisor;
        end else if (busy_reg) begin
            if (!diff[32]) begin
                rem_next = diff;
                quo_next = {quo_reg[DIVD_W-2:0], 1'b1};
            end else begin
                rem_next = shifted;
                quo_next = {quo_reg[DIVD_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == DIV_CNT_W'(1)) begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
    end

    assign busy = busy_reg;
    // zero count gives zero mean; saturate above 40 bits
    always_comb begin
        if (dsr_reg == '0) begin
            mean = '0;
        end else if (|quo_reg[DIVD_W-1:MEAN_W]) begin
            mean = '1;
        end else begin
            mean = quo_reg[MEAN_W-1:0];
        end
    end
endmodule

// File: rtl/sdlt_datapath.sv
// slot table, counters, scan evaluation and output register
module sdlt_datapath (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  sdlt_pkg::sdlt_cmd_t        cmd,
    output sdlt_pkg::sdlt_sts_t        sts,
    input  logic [21:0]                in_data,
    input  logic                       cfg_valid,
    input  logic [1:0]                 cfg_index,
    input  logic [31:0]                cfg_data,
    input  logic                       out_ready,
    output logic                       out_valid,
    output logic [167:0]               out_data,
    output logic                       out_last
);
    import sdlt_pkg::*;

    logic [FRAC_W-1:0] hl_frac_reg, death_frac_reg;
    logic [TICK_W-1:0] max_age_reg;

    logic [SLOTS-1:0]  valid_reg, hl_done_reg, zdone_reg, die_reg, zomb_reg;
    logic [MAG_W-1:0]  peak_reg [SLOTS];
    logic [MAG_W-1:0]  cur_reg [SLOTS];
    logic [TICK_W-1:0] birth_reg [SLOTS];

    logic [TICK_W-1:0] now_reg, dead_cnt_reg, zomb_cnt_reg, hl_cnt_reg;
    logic [SUM_W-1:0]  hl_sum_reg;

    action_t           act_reg;
    logic [SLOT_W-1:0] slot_reg;
    logic [MAG_W-1:0]  mag_reg;

    logic              ovalid_reg;
    logic [167:0]      odata_reg, odata_next;
    logic              olast_reg, olast_next;

    logic [MAG_W-1:0]  in_mag;
    logic [15:0]       in_bias;
    logic [SLOT_W-1:0] si;
    logic [MAG_W+FRAC_W-1:0] cur_sh, hl_prod, dth_prod;
    logic [TICK_W-1:0] age_s;
    logic              hl_hit, dth_hit, zmb_hit;
    logic [CNT_W-1:0]  active;
    logic              div_busy;
    logic [MEAN_W-1:0] mean;

    assign in_bias = in_data[21:6];
    assign in_mag  = in_bias[15] ? MAG_W'(17'h10000 - {1'b0, in_bias}) : in_bias;

    assign si       = cmd.scan_idx;
    assign cur_sh   = {1'b0, cur_reg[si], 16'h0};
    assign hl_prod  = {{FRAC_W{1'b0}}, peak_reg[si]} * {{MAG_W{1'b0}}, hl_frac_reg};
    assign dth_prod = {{FRAC_W{1'b0}}, peak_reg[si]} * {{MAG_W{1'b0}}, death_frac_reg};
    assign age_s    = now_reg - birth_reg[si];
    assign hl_hit   = valid_reg[si] && !hl_done_reg[si] && (cur_sh <= hl_prod);
    assign dth_hit  = valid_reg[si] && (cur_sh <= dth_prod);
    assign zmb_hit  = valid_reg[si] && !dth_hit && !zdone_reg[si] &&
                      (age_s > max_age_reg);

    always_comb begin
        active = '0;
        for (int i = 0; i < SLOTS; i++) begin
            active = active + CNT_W'(valid_reg[i]);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hl_frac_reg    <= FRAC_W'(32768);
            death_frac_reg <= FRAC_W'(6554);
            max_age_reg    <= TICK_W'(1000);
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_HALFLIFE: hl_frac_reg    <= cfg_data[FRAC_W-1:0];
                REG_DEATH:    death_frac_reg <= cfg_data[FRAC_W-1:0];
                REG_MAXAGE:   max_age_reg    <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            act_reg  <= action_t'(in_data[1:0]);
            slot_reg <= in_data[5:2];
            mag_reg  <= in_mag;
        end
        if (cmd.record && !valid_reg[slot_reg]) begin
            peak_reg[slot_reg]  <= mag_reg;
            cur_reg[slot_reg]   <= mag_reg;
            birth_reg[slot_reg] <= now_reg;
        end else if (cmd.record) begin
            cur_reg[slot_reg] <= mag_reg;
            if (mag_reg > peak_reg[slot_reg]) begin
                peak_reg[slot_reg] <= mag_reg;
            end
        end
        if (cmd.record && !valid_reg[slot_reg]) begin
            hl_done_reg[slot_reg] <= 1'b0;
            zdone_reg[slot_reg]   <= 1'b0;
        end else if (cmd.scan) begin
            if (hl_hit) hl_done_reg[si] <= 1'b1;
            if (zmb_hit) zdone_reg[si] <= 1'b1;
        end
        if (cmd.tick_inc) begin
            die_reg  <= '0;
            zomb_reg <= '0;
        end else if (cmd.scan) begin
            die_reg[si]  <= dth_hit;
            zomb_reg[si] <= zmb_hit;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg    <= '0;
            now_reg      <= '0;
            hl_sum_reg   <= '0;
            hl_cnt_reg   <= '0;
            dead_cnt_reg <= '0;
            zomb_cnt_reg <= '0;
        end else begin
            if (cmd.clear) begin
                valid_reg    <= '0;
                hl_sum_reg   <= '0;
                hl_cnt_reg   <= '0;
                dead_cnt_reg <= '0;
                zomb_cnt_reg <= '0;
            end
            if (cmd.record) valid_reg[slot_reg] <= 1'b1;
            if (cmd.commit_die) valid_reg <= valid_reg & ~die_reg;
            if (cmd.tick_inc) now_reg <= now_reg + TICK_W'(1);
            if (cmd.scan) begin
                if (hl_hit) begin
                    hl_sum_reg <= hl_sum_reg + SUM_W'(age_s);
                    hl_cnt_reg <= hl_cnt_reg + TICK_W'(1);
                end
                if (dth_hit) dead_cnt_reg <= dead_cnt_reg + TICK_W'(1);
                if (zmb_hit) zomb_cnt_reg <= zomb_cnt_reg + TICK_W'(1);
            end
        end
    end

    sdlt_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.div_start),
        .dividend ({hl_sum_reg, 8'h0}),
        .divisor  (hl_cnt_reg),
        .busy     (div_busy),
        .mean     (mean)
    );

    // output word: kind, slot, age, peak, active, dead, zombie, mean
    always_comb begin
        odata_next      = '0;
        olast_next      = 1'b0;
        odata_next[1:0] = cmd.out_kind;
        if (cmd.out_kind == KIND_STATS) begin
            odata_next[58:54]   = active;
            odata_next[90:59]   = dead_cnt_reg;
            odata_next[122:91]  = zomb_cnt_reg;
            odata_next[162:123] = mean;
            olast_next          = 1'b1;
        end else begin
            odata_next[5:2]  = cmd.out_slot;
            odata_next[37:6] = now_reg - birth_reg[cmd.out_slot];
            if (cmd.out_kind == KIND_DEATH) begin
                odata_next[53:38] = peak_reg[cmd.out_slot];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ovalid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            ovalid_reg <= 1'b1;
        end else if (out_ready) begin
            ovalid_reg <= 1'b0;
        end
        if (cmd.out_load) begin
            odata_reg <= odata_next;
            olast_reg <= olast_next;
        end
    end

    assign out_valid = ovalid_reg;
    assign out_data  = odata_reg;
    assign out_last  = olast_reg;

    assign sts.action    = act_reg;
    assign sts.die_mask  = die_reg;
    assign sts.zomb_mask = zomb_reg;
    assign sts.div_busy  = div_busy;
    assign sts.out_full  = ovalid_reg && !out_ready;
endmodule

// File: rtl/sdlt_ctrl.sv
// sequencer for record, tick scan, event emission and statistics
module sdlt_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_valid,
    output logic                in_ready,
    output sdlt_pkg::sdlt_cmd_t cmd,
    input  sdlt_pkg::sdlt_sts_t sts
);
    import sdlt_pkg::*;

    typedef enum logic [6:0] {
        ST_IDLE  = 7'b0000001,
        ST_EXEC  = 7'b0000010,
        ST_SCAN  = 7'b0000100,
        ST_DEATH = 7'b0001000,
        ST_ZOMB  = 7'b0010000,
        ST_DIV   = 7'b0100000,
        ST_STATS = 7'b1000000
    } state_t;

    state_t            state_reg, state_next;
    logic [SLOT_W-1:0] idx_reg, idx_next;
    logic              can_out;
    logic              pend;

    assign can_out = !sts.out_full;

    always_comb begin
        state_next   = state_reg;
        idx_next     = idx_reg;
        cmd          = '0;
        cmd.scan_idx = idx_reg;
        cmd.out_slot = idx_reg;
        cmd.out_kind = KIND_STATS;
        in_ready     = 1'b0;
        pend         = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                idx_next = '0;
                case (sts.action)
                    ACT_RECORD: begin
                        cmd.record = 1'b1;
                        state_next = ST_DIV;
                        cmd.div_start = 1'b1;
                    end
                    ACT_TICK: begin
                        cmd.tick_inc = 1'b1;
                        state_next   = ST_SCAN;
                    end
                    ACT_CLEAR: begin
                        cmd.clear  = 1'b1;
                        state_next = ST_STATS;
                    end
                    default: begin
                        cmd.div_start = 1'b1;
                        state_next    = ST_DIV;
                    end
                endcase
            end
            ST_SCAN: begin
                cmd.scan = 1'b1;
                idx_next = idx_reg + 1'b1;
                if (idx_reg == SLOT_W'(SLOTS - 1)) begin
                    state_next = ST_DEATH;
                end
            end
            ST_DEATH: begin
                pend = sts.die_mask[idx_reg];
                if (!pend || can_out) begin
                    cmd.out_load = pend;
                    cmd.out_kind = KIND_DEATH;
                    idx_next     = idx_reg + 1'b1;
                    if (idx_reg == SLOT_W'(SLOTS - 1)) begin
                        cmd.commit_die = 1'b1;
                        state_next     = ST_ZOMB;
                    end
                end
            end
            ST_ZOMB: begin
                pend = sts.zomb_mask[idx_reg];
                if (!pend || can_out) begin
                    cmd.out_load = pend;
                    cmd.out_kind = KIND_ZOMBIE;
                    idx_next     = idx_reg + 1'b1;
                    if (idx_reg == SLOT_W'(SLOTS - 1)) begin
                        cmd.div_start = 1'b1;
                        state_next    = ST_DIV;
                    end
                end
            end
            ST_DIV: begin
                if (!sts.div_busy) begin
                    state_next = ST_STATS;
                end
            end
            ST_STATS: begin
                if (sts.action == ACT_CLEAR && !sts.div_busy && idx_reg == '0) begin
                    // clear: counters now zero, run divider for consistent mean
                    cmd.div_start = 1'b1;
                    idx_next      = SLOT_W'(1);
                    state_next    = ST_DIV;
                end else if (can_out) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            idx_reg   <= '0;
        end else begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
        end
    end
endmodule

// File: rtl/signal_decay_lifecycle_table_unit.sv
// top level of the signal decay lifecycle table
// record or idle action: runs the 56-step divider for the mean
// tick: scan of every slot, death and zombie event walks, then the divide, plus output stalls
// one word in flight at a time; next word taken after the statistics word is loaded
// reset: aresetn low clears valid bits, counters and now tick; registers to defaults
module signal_decay_lifecycle_table_unit (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [23:0]  s_tdata,   // action[1:0], slot[5:2], bias[21:6], zero pad
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [1:0]   cfg_index,
    input  logic [31:0]  cfg_data,
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [167:0] m_tdata,   // kind, event_slot, age_ticks, peak_mag,
                                    // active_count, dead_total, zombie_total,
                                    // mean_halflife, zero pad
    output logic         m_tlast
);
    import sdlt_pkg::*;

    sdlt_cmd_t cmd;
    sdlt_sts_t sts;

    assign cfg_ready = 1'b1;

    sdlt_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .cmd      (cmd),
        .sts      (sts)
    );

    sdlt_datapath u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .sts       (sts),
        .in_data   (s_tdata[21:0]),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .out_ready (m_tready),
        .out_valid (m_tvalid),
        .out_data  (m_tdata),
        .out_last  (m_tlast)
    );
endmodule

// File: tb/sv/decay_table_checker.sv
// result checker for the signal decay lifecycle table: predicts and compares every result word
module decay_table_checker (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    input  logic         s_tready,
    input  logic [23:0]  s_tdata,
    input  logic         cfg_valid,
    input  logic         cfg_ready,
    input  logic [1:0]   cfg_index,
    input  logic [31:0]  cfg_data,
    input  logic         m_tvalid,
    input  logic         m_tready,
    input  logic [167:0] m_tdata,
    input  logic         m_tlast,
    output int           fail_count,
    output int           pending,
    output int           results_seen,
    output int           deaths_seen,
    output int           zombies_seen
);
    timeunit 1ns;
    timeprecision 1ps;
    import sdlt_pkg::*;

    typedef struct {
        kind_t       kind;
        logic [3:0]  slot;
        logic [31:0] age;
        logic [15:0] peak;
        logic [4:0]  active;
        logic [31:0] dead;
        logic [31:0] zomb;
        logic [39:0] mean;
        logic        last;
    } decay_result_t;

    decay_result_t expected_results[$];

    // model copy of the table
    logic [16:0] halflife_frac, death_frac;
    logic [31:0] max_age;
    logic        slot_live  [SLOTS];
    logic [15:0] peak_mag_q [SLOTS];
    logic [15:0] cur_mag_q  [SLOTS];
    logic [31:0] birth_q    [SLOTS];
    logic        hl_done    [SLOTS];
    logic        zb_done    [SLOTS];
    logic [31:0] now_tick, hl_count, death_cnt, zombie_cnt;
    logic [47:0] hl_sum;

    task automatic clear_table();
        for (int i = 0; i < SLOTS; i++) slot_live[i] = 1'b0;
        hl_sum = '0;
        hl_count = '0;
        death_cnt = '0;
        zombie_cnt = '0;
    endtask

    task automatic push_event(kind_t k, int s, logic [31:0] age, logic [15:0] pk);
        decay_result_t r;
        r = '{kind: k, slot: 4'(s), age: age, peak: pk, active: '0, dead: '0,
              zomb: '0, mean: '0, last: 1'b0};
        expected_results.insert(expected_results.size(), r);
    endtask

    task automatic predict_item(logic [23:0] w);
        action_t     act;
        logic [3:0]  slot;
        logic [15:0] b;
        logic [15:0] mag;
        logic        dies [SLOTS];
        logic        zomb [SLOTS];
        logic [31:0] age  [SLOTS];
        logic [63:0] cur_s, q;
        int          live_n;
        decay_result_t r;
        act  = action_t'(w[1:0]);
        slot = w[5:2];
        b    = w[21:6];
        mag  = b[15] ? 16'(17'h10000 - {1'b0, b}) : b;
        case (act)
            ACT_RECORD: begin
                if (!slot_live[slot]) begin
                    slot_live[slot] = 1'b1;
                    peak_mag_q[slot] = mag;
                    cur_mag_q[slot] = mag;
                    birth_q[slot] = now_tick;
                    hl_done[slot] = 1'b0;
                    zb_done[slot] = 1'b0;
                end else begin
                    cur_mag_q[slot] = mag;
                    if (mag > peak_mag_q[slot]) peak_mag_q[slot] = mag;
                end
            end
            ACT_TICK: begin
                now_tick = now_tick + 1;
                for (int i = 0; i < SLOTS; i++) begin
                    dies[i] = 1'b0;
                    zomb[i] = 1'b0;
                    age[i] = '0;
                    if (!slot_live[i]) continue;
                    cur_s = 64'(cur_mag_q[i]) << 16;
                    age[i] = now_tick - birth_q[i];
                    if (!hl_done[i] && cur_s <= 64'(peak_mag_q[i]) * 64'(halflife_frac)) begin
                        hl_done[i] = 1'b1;
                        hl_sum = hl_sum + 48'(age[i]);
                        hl_count = hl_count + 1;
                    end
                    if (cur_s <= 64'(peak_mag_q[i]) * 64'(death_frac)) begin
                        dies[i] = 1'b1;
                        death_cnt = death_cnt + 1;
                        continue;
                    end
                    if (!zb_done[i] && age[i] > max_age) begin
                        zb_done[i] = 1'b1;
                        zomb[i] = 1'b1;
                        zombie_cnt = zombie_cnt + 1;
                    end
                end
                for (int i = 0; i < SLOTS; i++)
                    if (dies[i]) begin
                        push_event(KIND_DEATH, i, age[i], peak_mag_q[i]);
                        slot_live[i] = 1'b0;
                    end
                for (int i = 0; i < SLOTS; i++)
                    if (zomb[i]) push_event(KIND_ZOMBIE, i, age[i], '0);
            end
            ACT_CLEAR: clear_table();
            default: ;
        endcase
        live_n = 0;
        for (int i = 0; i < SLOTS; i++) if (slot_live[i]) live_n++;
        if (hl_count == 0) q = '0;
        else begin
            q = {8'd0, hl_sum, 8'd0} / 64'(hl_count);
            if (q > 64'hFF_FFFF_FFFF) q = 64'hFF_FFFF_FFFF;
        end
        r = '{kind: KIND_STATS, slot: '0, age: '0, peak: '0, active: 5'(live_n),
              dead: death_cnt, zomb: zombie_cnt, mean: q[39:0], last: 1'b1};
        expected_results.insert(expected_results.size(), r);
    endtask

    function automatic bit field_ok(string name, logic [63:0] exp_v, logic [63:0] act_v);
        if (exp_v !== act_v) begin
            $display("%0t: mismatch in %s: expected %0h, actual %0h", $time, name, exp_v, act_v);
            return 0;
        end
        return 1;
    endfunction

    task automatic check_word();
        decay_result_t e;
        bit ok;
        results_seen++;
        if (expected_results.size() == 0) begin
            $display("%0t: result word with nothing expected, actual %h last %b",
                     $time, m_tdata, m_tlast);
            fail_count++;
            return;
        end
        e = expected_results.pop_front();
        if (e.kind == KIND_DEATH) deaths_seen++;
        if (e.kind == KIND_ZOMBIE) zombies_seen++;
        ok = 1;
        ok &= field_ok("kind",          64'(e.kind),   64'(m_tdata[1:0]));
        ok &= field_ok("event_slot",    64'(e.slot),   64'(m_tdata[5:2]));
        ok &= field_ok("age_ticks",     64'(e.age),    64'(m_tdata[37:6]));
        ok &= field_ok("peak_mag",      64'(e.peak),   64'(m_tdata[53:38]));
        ok &= field_ok("active_count",  64'(e.active), 64'(m_tdata[58:54]));
        ok &= field_ok("dead_total",    64'(e.dead),   64'(m_tdata[90:59]));
        ok &= field_ok("zombie_total",  64'(e.zomb),   64'(m_tdata[122:91]));
        ok &= field_ok("mean_halflife", 64'(e.mean),   64'(m_tdata[162:123]));
        ok &= field_ok("last",          64'(e.last),   64'(m_tlast));
        if (!ok) fail_count++;
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            halflife_frac = 17'd32768;
            death_frac = 17'd6554;
            max_age = 32'd1000;
            now_tick = '0;
            clear_table();
            expected_results.delete();
            fail_count = 0;
            results_seen = 0;
            deaths_seen = 0;
            zombies_seen = 0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_HALFLIFE: halflife_frac = cfg_data[16:0];
                    REG_DEATH:    death_frac = cfg_data[16:0];
                    REG_MAXAGE:   max_age = cfg_data;
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready) predict_item(s_tdata);
            if (m_tvalid && m_tready) check_word();
        end
        pending = expected_results.size();
    end

endmodule

// File: tb/sv/tb_signal_decay_lifecycle_table_unit.sv
// testbench top for the signal decay lifecycle table: clock, reset, stimulus and verdict
module tb_signal_decay_lifecycle_table_unit;
    timeunit 1ns;
    timeprecision 1ps;
    import sdlt_pkg::*;

    localparam int CYCLE_LIMIT = 3_000_000;

    logic         aclk;
    logic         aresetn;
    logic         s_tvalid, s_tready;
    logic [23:0]  s_tdata;
    logic         cfg_valid, cfg_ready;
    logic [1:0]   cfg_index;
    logic [31:0]  cfg_data;
    logic         m_tvalid, m_tready;
    logic [167:0] m_tdata;
    logic         m_tlast;

    int fail_count, pending, results_seen, deaths_seen, zombies_seen;
    int send_idle = 24;
    int recv_idle = 24;
    int words_sent = 0;
    int cycles = 0;

    signal_decay_lifecycle_table_unit u_dut (.*);

    decay_table_checker u_checker (.*);

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding", cycles, pending);
            $display("FAILURE");
            $finish;
        end
    end

    always @(negedge aclk) m_tready <= ($urandom_range(0, 99) >= recv_idle);

    task automatic send_word(action_t act, logic [3:0] slot, logic [15:0] bias);
        while ($urandom_range(0, 99) < send_idle) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {2'b00, bias, slot, act};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        words_sent++;
        @(negedge aclk);
    endtask

    // stop sending and let the table drain before anything else happens
    task automatic drain();
        s_tvalid <= 1'b0;
        @(negedge aclk);
        while (pending != 0) @(negedge aclk);
        repeat (250) @(negedge aclk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [31:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        @(negedge aclk);
        cfg_valid <= 1'b0;
        @(negedge aclk);
    endtask

    task automatic random_word();
        int          r;
        logic [15:0] bias;
        r = $urandom_range(0, 99);
        case ($urandom_range(0, 9)) inside
            [0:3]:   bias = 16'($urandom);
            [4:6]:   bias = 16'($urandom_range(0, 4000));
            7:       bias = 16'(-$urandom_range(0, 4000));
            default: bias = 16'($urandom_range(0, 3));
        endcase
        if (r < 56)      send_word(ACT_RECORD, 4'($urandom), bias);
        else if (r < 94) send_word(ACT_TICK, 4'($urandom), 16'($urandom));
        else if (r < 97) send_word(ACT_CLEAR, 4'($urandom), 16'($urandom));
        else             send_word(ACT_NONE, 4'($urandom), 16'($urandom));
    endtask

    task automatic random_run(int n);
        for (int i = 0; i < n; i++) random_word();
    endtask

    initial begin
        aresetn   = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        repeat (11) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // directed: field extremes, every action, zero peak, decay and clear
        send_word(ACT_RECORD, 4'd0, 16'h7FFF);
        send_word(ACT_RECORD, 4'd1, 16'h8000);
        send_word(ACT_RECORD, 4'd2, 16'h0000);
        send_word(ACT_RECORD, 4'd15, 16'hFFFF);
        send_word(ACT_TICK, 4'd0, 16'h0000);
        send_word(ACT_RECORD, 4'd0, 16'd16000);
        send_word(ACT_RECORD, 4'd1, 16'h0001);
        send_word(ACT_RECORD, 4'd15, 16'h0002);
        send_word(ACT_TICK, 4'd15, 16'hFFFF);
        send_word(ACT_RECORD, 4'd0, 16'd100);
        send_word(ACT_TICK, 4'd0, 16'h0000);
        send_word(ACT_NONE, 4'd15, 16'hFFFF);
        send_word(ACT_RECORD, 4'd3, 16'h5555);
        send_word(ACT_RECORD, 4'd12, 16'hAAAA);
        send_word(ACT_CLEAR, 4'd0, 16'h0000);
        send_word(ACT_TICK, 4'd0, 16'h0000);
        send_word(ACT_RECORD, 4'd5, 16'd1000);
        send_word(ACT_TICK, 4'd0, 16'h0000);
        drain();

        // zombies right away, half-life fraction at full scale, only zero-magnitude slots die
        write_reg(REG_HALFLIFE, 32'd65536);
        write_reg(REG_DEATH, 32'd0);
        write_reg(REG_MAXAGE, 32'd0);
        write_reg(2'd3, 32'hFFFF_FFFF);
        random_run(90);
        drain();

        // everything dies, never zombie
        write_reg(REG_HALFLIFE, 32'd0);
        write_reg(REG_DEATH, 32'd65536);
        write_reg(REG_MAXAGE, 32'hFFFF_FFFF);
        random_run(60);
        drain();

        // half-life fraction above one, long stretch without any idling
        write_reg(REG_HALFLIFE, 32'd131071);
        write_reg(REG_DEATH, 32'd6554);
        write_reg(REG_MAXAGE, 32'd2);
        send_idle = 0;
        recv_idle = 0;
        random_run(120);
        send_idle = 24;
        recv_idle = 24;
        drain();

        write_reg(REG_HALFLIFE, 32'd32768);
        write_reg(REG_DEATH, 32'd20000);
        write_reg(REG_MAXAGE, 32'd5);
        random_run(110);
        drain();

        write_reg(REG_MAXAGE, 32'd1000);
        random_run(100);
        drain();

        $display("sent %0d input words, checked %0d result words", words_sent, results_seen);
        $display("saw %0d death and %0d zombie events across six register settings",
                 deaths_seen, zombies_seen);
        if (fail_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("%0d failing result words", fail_count);
            $display("FAILURE");
        end
        $finish;
    end

endmodule

// File: files.f
rtl/sdlt_pkg.sv
rtl/sdlt_div.sv
rtl/sdlt_datapath.sv
rtl/sdlt_ctrl.sv
rtl/signal_decay_lifecycle_table_unit.sv
tb/sv/decay_table_checker.sv
tb/sv/tb_signal_decay_lifecycle_table_unit.sv
